/* rtl/core/smsmm_pkg.sv */
// ----------------------------------------------------------------------------
// smsmm_pkg
// Shared widths, constants and types for the set statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package smsmm_pkg;

  localparam int SMP_W       = 15;
  localparam int MAX_SAMPLES = 128;
  localparam logic [SMP_W-1:0] FULL_SCALE = 15'd25600;

  localparam longint SUM_MAX = longint'(MAX_SAMPLES) * 64'd25600;
  localparam longint SQ_MAX  = longint'(MAX_SAMPLES) * 64'd655360000;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = $clog2(SUM_MAX + 1);
  localparam int SQ_W   = $clog2(SQ_MAX + 1);
  localparam int NUM_W  = CNT_W + SQ_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int RT_W   = (NUM_W + 1) / 2;
  localparam int WK_W   = 2 * RT_W;
  localparam int SUB_W  = (DEN_W + 1 > RT_W + 3) ? DEN_W + 1 : RT_W + 3;
  localparam int IT_W   = $clog2(WK_W + 1);
  localparam int PROD_W = SQ_W + SUM_W;

  localparam int COUNT_OUT_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT
  } ds_op_t;

  typedef struct packed {
    logic             start;
    ds_op_t           op;
    logic [NUM_W-1:0] operand;
    logic [DEN_W-1:0] divisor;
  } ds_cmd_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ADD,
    S_FIN,
    S_MUL_SQ,
    S_MUL_SUM,
    S_MUL_DEN,
    S_VAR,
    S_VAR_WAIT,
    S_ROOT,
    S_ROOT_WAIT,
    S_MEAN,
    S_MEAN_WAIT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/smsmm_acc.sv */
// ----------------------------------------------------------------------------
// smsmm_acc
// Running count, sum, sum of squares, minimum, maximum and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module smsmm_acc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire smsmm_pkg::acc_ctl_t           ctl,
  input  wire logic [smsmm_pkg::SMP_W-1:0]   sample,
  input  wire logic [2*smsmm_pkg::SMP_W-1:0] square,
  output logic      [smsmm_pkg::CNT_W-1:0]   count,
  output logic      [smsmm_pkg::SUM_W-1:0]   sum,
  output logic      [smsmm_pkg::SQ_W-1:0]    sumsq,
  output logic      [smsmm_pkg::SMP_W-1:0]   least,
  output logic      [smsmm_pkg::SMP_W-1:0]   greatest,
  output logic                               ovf
);
  import smsmm_pkg::*;

  logic room;

  assign room = count < CNT_W'(MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count    <= '0;
      sum      <= '0;
      sumsq    <= '0;
      least    <= FULL_SCALE;
      greatest <= '0;
      ovf      <= 1'b0;
    end else if (ctl.add) begin
      if (room) begin
        count <= count + CNT_W'(1);
        sum   <= sum + SUM_W'(sample);
        sumsq <= sumsq + SQ_W'(square);
        if (sample < least) begin
          least <= sample;
        end
        if (sample > greatest) begin
          greatest <= sample;
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/smsmm_divsqrt.sv */
// ----------------------------------------------------------------------------
// smsmm_divsqrt
// Shared iterative unit: restoring divide or digit-by-digit square root,
// one bit of result per cycle through a single subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module smsmm_divsqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire smsmm_pkg::ds_cmd_t         cmd,
  output logic                            done,
  output logic [smsmm_pkg::WK_W-1:0]      result
);
  import smsmm_pkg::*;

  logic             busy;
  logic [IT_W-1:0]  iter;
  ds_op_t           op;
  logic [WK_W-1:0]  work;
  logic [SUB_W-1:0] rem;
  logic [RT_W-1:0]  root;
  logic [DEN_W-1:0] divisor_r;

  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W:0]   diff;
  logic             fits;

  always_comb begin
    unique case (op)
      OP_SQRT: begin
        sub_a = {rem[SUB_W-3:0], work[WK_W-1:WK_W-2]};
        sub_b = SUB_W'({root, 2'b01});
      end
      default: begin
        sub_a = {rem[SUB_W-2:0], work[WK_W-1]};
        sub_b = SUB_W'(divisor_r);
      end
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    fits = !diff[SUB_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        iter <= (cmd.op == OP_SQRT) ? IT_W'(RT_W) : IT_W'(WK_W);
      end else if (busy) begin
        iter <= iter - IT_W'(1);
        if (iter == IT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op        <= cmd.op;
      work      <= WK_W'(cmd.operand);
      divisor_r <= cmd.divisor;
      rem       <= '0;
      root      <= '0;
    end else if (busy) begin
      if (op == OP_SQRT) begin
        work <= {work[WK_W-3:0], 2'b00};
        rem  <= fits ? diff[SUB_W-1:0] : sub_a;
        root <= {root[RT_W-2:0], fits};
      end else begin
        work <= {work[WK_W-2:0], fits};
        rem  <= fits ? diff[SUB_W-1:0] : sub_a;
      end
    end
  end

  assign result = (op == OP_SQRT) ? WK_W'(root) : work;

endmodule

`default_nettype wire

/* rtl/core/set_mean_stddev_min_max.sv */
// ----------------------------------------------------------------------------
// set_mean_stddev_min_max
// Mean, sample standard deviation, minimum and maximum of a set of Q7.8
// scores, one result word per set on the word marked last.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                     tlast
//  s_axis   in   sample                    last sample of the set
//  m_axis   out  mean, std_dev, minimum,   -
//                maximum, count, too_few,
//                overflowed
//
//  each input word passes through accept, square and accumulate
//  the last word adds the closing run: for two or more samples the n*sumsq, sum*sum
//  and n*(n-1) multiplies, variance divide, root and mean divide; for one only the mean
//  the shared divide/root unit gives one result bit a cycle
//  s_tready is low from acceptance until the set is closed or the word done
//  a waiting result word stalls only the closing of the next set
//  rst is synchronous and clears the accumulators and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module set_mean_stddev_min_max (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [smsmm_pkg::IN_TDATA_W-1:0]     s_tdata,  // sample[14:0]
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // mean[14:0], std_dev[29:15], minimum[44:30], maximum[59:45],
  // count[67:60], too_few[68], overflowed[69]
  output logic      [smsmm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import smsmm_pkg::*;

  state_t state;
  state_t state_next;

  logic [SMP_W-1:0]  smp;
  logic [SMP_W-1:0]  smp_sat;
  logic              last_r;
  logic [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]  num_a;
  logic [NUM_W-1:0]  num;
  logic [SMP_W-1:0]  sd;
  logic [SMP_W-1:0]  mean;

  logic [SQ_W-1:0]   mul_a;
  logic [SUM_W-1:0]  mul_b;
  logic [PROD_W-1:0] product;

  acc_ctl_t          acc_ctl;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [SQ_W-1:0]   sumsq;
  logic [SMP_W-1:0]  least;
  logic [SMP_W-1:0]  greatest;
  logic              ovf;

  ds_cmd_t           ds_cmd;
  logic              ds_done;
  logic [WK_W-1:0]   ds_res;

  logic              accept;
  logic              out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign smp_sat  = (s_tdata[SMP_W-1:0] > FULL_SCALE) ? FULL_SCALE : s_tdata[SMP_W-1:0];

  smsmm_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (acc_ctl),
    .sample   (smp),
    .square   (prod[2*SMP_W-1:0]),
    .count    (count),
    .sum      (sum),
    .sumsq    (sumsq),
    .least    (least),
    .greatest (greatest),
    .ovf      (ovf)
  );

  smsmm_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ds_cmd),
    .done   (ds_done),
    .result (ds_res)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = SQ_W'(smp);
        mul_b = SUM_W'(smp);
      end
      S_MUL_SQ: begin
        mul_a = sumsq;
        mul_b = SUM_W'(count);
      end
      S_MUL_SUM: begin
        mul_a = SQ_W'(sum);
        mul_b = sum;
      end
      S_MUL_DEN: begin
        mul_a = SQ_W'(count);
        mul_b = SUM_W'(count - CNT_W'(1));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    acc_ctl.clear  = 1'b0;
    acc_ctl.add    = 1'b0;
    ds_cmd.start   = 1'b0;
    ds_cmd.op      = OP_DIV;
    ds_cmd.operand = num;
    ds_cmd.divisor = prod[DEN_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        acc_ctl.add = 1'b1;
        state_next  = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (count >= CNT_W'(2)) begin
          state_next = S_MUL_SQ;
        end else if (count == CNT_W'(1)) begin
          state_next = S_MEAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MUL_SQ: begin
        state_next = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        state_next = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        state_next = S_VAR;
      end
      S_VAR: begin
        ds_cmd.start = 1'b1;
        state_next   = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (ds_done) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        ds_cmd.start   = 1'b1;
        ds_cmd.op      = OP_SQRT;
        ds_cmd.operand = ds_res[NUM_W-1:0];
        state_next     = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (ds_done) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        ds_cmd.start   = 1'b1;
        ds_cmd.operand = NUM_W'(sum);
        ds_cmd.divisor = DEN_W'(count);
        state_next     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (ds_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          acc_ctl.clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      smp    <= smp_sat;
      last_r <= s_tlast;
    end
    case (state) inside
      S_SQ, S_MUL_SQ, S_MUL_DEN: begin
        prod <= product[NUM_W-1:0];
      end
      S_MUL_SUM: begin
        num_a <= prod;
        prod  <= product[NUM_W-1:0];
      end
      default: begin
      end
    endcase
    if (state == S_MUL_DEN) begin
      num <= (num_a > prod) ? (num_a - prod) : '0;
    end
    if (state == S_FIN) begin
      sd   <= '0;
      mean <= '0;
    end
    if (state == S_ROOT_WAIT && ds_done) begin
      sd <= ds_res[SMP_W-1:0];
    end
    if (state == S_MEAN_WAIT && ds_done) begin
      mean <= ds_res[SMP_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {2'b00, ovf, (count == CNT_W'(1)), COUNT_OUT_W'(count),
                  greatest, least, sd, mean};
    end
  end

endmodule

`default_nettype wire
